// File: sv/rbsa_pkg.sv
`default_nettype none
package rbsa_pkg;
    localparam int unsigned CNT_W = 16;
    localparam int unsigned SUM_W = 32;
    localparam logic CMD_ACCUM = 1'b0;
    localparam logic CMD_REPORT = 1'b1;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // One accepted item as it travels from the front to the back.
    typedef struct packed {
        logic        cmd;
        logic [11:0] row;
        logic        row_ok;
        logic [31:0] m;
        logic [32:0] cov;
    } item_t;

    // Back-end engine states.
    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_RD    = 8'b0000_0010,
        ST_DIVB  = 8'b0000_0100,
        ST_SQ    = 8'b0000_1000,
        ST_WR    = 8'b0001_0000,
        ST_RDIV  = 8'b0010_0000,
        ST_SQRT  = 8'b0100_0000,
        ST_OUT   = 8'b1000_0000
    } state_t;
endpackage
`default_nettype wire

// File: sv/rbsa_ram.sv
`default_nettype none
module rbsa_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Single write port, registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// File: sv/rbsa_front.sv
`default_nettype none
module rbsa_front #(
    parameter int unsigned ROW_COUNT = 4096
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_we,
    input  wire logic [31:0]        cfg_wdata,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               in_cmd,
    input  wire logic [11:0]        in_row,
    input  wire logic [31:0]        in_m,
    input  wire logic [31:0]        in_u,
    output logic                    q_valid,
    input  wire logic               q_ready,
    output rbsa_pkg::item_t         q_item
);
    localparam int unsigned QD = 2;

    logic [31:0]           min_cov_reg;
    rbsa_pkg::item_t       q_mem [QD];
    logic                  wp_reg, rp_reg;
    logic [1:0]            cnt_reg;
    logic [32:0]           cov;
    logic                  keep, row_ok, push, pop;
    rbsa_pkg::item_t       it;

    // Coverage threshold register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_cov_reg <= 32'd1;
        end else if (cfg_we) begin
            min_cov_reg <= cfg_wdata;
        end
    end

    // Classify: skipped accumulates never reach the queue.
    always_comb begin
        cov = {1'b0, in_m} + {1'b0, in_u};
        row_ok = ({20'd0, in_row} < 32'(ROW_COUNT));
        keep = (in_cmd == rbsa_pkg::CMD_REPORT) ||
               (row_ok && cov != 33'd0 && cov >= {1'b0, min_cov_reg});
        it.cmd = in_cmd;
        it.row = in_row;
        it.row_ok = row_ok;
        it.m = in_m;
        it.cov = cov;
    end

    assign in_ready = (cnt_reg != 2'(QD));
    assign push = in_valid && in_ready && keep;
    assign pop = q_valid && q_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item = q_mem[rp_reg];

    // Two-entry queue between front and back.
    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wp_reg] <= it;
        end
        if (!aresetn) begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule
`default_nettype wire

// File: sv/rbsa_back.sv
`default_nettype none
module rbsa_back #(
    parameter int unsigned ROW_COUNT = 4096,
    parameter int unsigned BETA_FRAC_BITS = 16
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    q_valid,
    output logic                         q_ready,
    input  wire rbsa_pkg::item_t         q_item,
    output logic                         o_valid,
    input  wire logic                    o_ready,
    output logic [11:0]                  o_row,
    output logic [15:0]                  o_n,
    output logic [BETA_FRAC_BITS:0]      o_mean,
    output logic [BETA_FRAC_BITS:0]      o_sd,
    output logic [BETA_FRAC_BITS:0]      o_gap,
    output logic [15:0]                  o_mn,
    output logic [BETA_FRAC_BITS:0]      o_sep,
    output logic                         o_has,
    output logic                         o_both
);
    localparam int unsigned F = BETA_FRAC_BITS;
    localparam int unsigned BW = F + 1;
    localparam int unsigned AW = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
    localparam int unsigned DEPTH = 1 << AW;
    // Packed row record: n, sum, sq, lmax, hmin, lsum, hsum, ln, hn.
    localparam int unsigned RW = 16*3 + 32*4 + 2*BW;
    localparam int unsigned CW = AW + 1;
    localparam int unsigned NW = 33 + F;
    localparam int unsigned SW = 2*F + 2;
    localparam logic [BW-1:0] ONE_Q = BW'(1) << F;
    localparam logic [BW-1:0] HALF_Q = BW'(1) << (F - 1);

    typedef struct packed {
        logic [15:0]   n;
        logic [31:0]   sum;
        logic [31:0]   sq;
        logic [BW-1:0] lmax;
        logic [BW-1:0] hmin;
        logic [31:0]   lsum;
        logic [31:0]   hsum;
        logic [15:0]   ln;
        logic [15:0]   hn;
    } rec_t;

    rbsa_pkg::state_t state_reg;
    rbsa_pkg::item_t  cur_reg;
    logic [CW-1:0]    clr_reg;
    logic             clr_done;
    logic             ram_we;
    logic [AW-1:0]    waddr, raddr;
    logic [RW-1:0]    wdata, rdata;
    rec_t             rec_reg, rd_rec, upd;

    // Shared restoring divider: quotient in num, remainder in rem.
    logic [NW-1:0]    num_reg;
    logic [32:0]      den_reg;
    logic [33:0]      rem_reg;
    logic [5:0]       step_reg;
    logic [1:0]       ph_reg;
    logic [33:0]      rem_sh;
    logic [BW-1:0]    x_reg;
    logic [31:0]      sq_add;
    logic [BW-1:0]    mean_reg, hm_reg, lm_reg;
    logic [31:0]      e2_reg;

    // Square-root unit over 2F+2 bits.
    logic [SW-1:0]    sv_reg, sr_reg, sb_reg;
    logic [2*BW-1:0]  prod;

    assign clr_done = clr_reg[AW] || (clr_reg == CW'(DEPTH));
    assign rd_rec = rdata;
    assign q_ready = (state_reg == rbsa_pkg::ST_IDLE) && clr_done && !o_valid;
    assign raddr = q_item.row[AW-1:0];
    assign rem_sh = {rem_reg[32:0], num_reg[NW-1]};
    assign prod = x_reg * mean_reg;
    // Squared beta scaled back to Q1.F; x and mean both hold beta while writing.
    assign sq_add = 32'(prod >> F);

    rbsa_ram #(.WIDTH(RW), .DEPTH(DEPTH)) u_ram (
        .aclk(aclk), .we(ram_we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    // Row update from the registered beta and square.
    always_comb begin
        upd = rec_reg;
        upd.n = rec_reg.n + 16'd1;
        upd.sum = ({1'b0, rec_reg.sum} + 33'(x_reg) > {1'b0, rbsa_pkg::SUM_MAX})
                  ? rbsa_pkg::SUM_MAX : rec_reg.sum + 32'(x_reg);
        upd.sq = ({1'b0, rec_reg.sq} + 33'(sq_add) > {1'b0, rbsa_pkg::SUM_MAX})
                 ? rbsa_pkg::SUM_MAX : rec_reg.sq + sq_add;
        if (x_reg < HALF_Q) begin
            upd.ln = (rec_reg.ln == rbsa_pkg::CNT_MAX) ? rec_reg.ln : rec_reg.ln + 16'd1;
            upd.lsum = ({1'b0, rec_reg.lsum} + 33'(x_reg) > {1'b0, rbsa_pkg::SUM_MAX})
                       ? rbsa_pkg::SUM_MAX : rec_reg.lsum + 32'(x_reg);
            if (x_reg > rec_reg.lmax) upd.lmax = x_reg;
        end
        if (x_reg > HALF_Q) begin
            upd.hn = (rec_reg.hn == rbsa_pkg::CNT_MAX) ? rec_reg.hn : rec_reg.hn + 16'd1;
            upd.hsum = ({1'b0, rec_reg.hsum} + 33'(x_reg) > {1'b0, rbsa_pkg::SUM_MAX})
                       ? rbsa_pkg::SUM_MAX : rec_reg.hsum + 32'(x_reg);
            if (x_reg < rec_reg.hmin) upd.hmin = x_reg;
        end
    end

    // Memory write: clearing pass after reset, else the update.
    always_comb begin
        rec_t z;
        z = '0;
        z.hmin = ONE_Q;
        if (!clr_done) begin
            ram_we = 1'b1;
            waddr = clr_reg[AW-1:0];
            wdata = z;
        end else begin
            ram_we = (state_reg == rbsa_pkg::ST_WR);
            waddr = cur_reg.row[AW-1:0];
            wdata = upd;
        end
    end

    // Back-end sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rbsa_pkg::ST_IDLE;
            clr_reg <= '0;
            o_valid <= 1'b0;
        end else begin
            if (!clr_done) clr_reg <= clr_reg + CW'(1);
            if (o_valid && o_ready) o_valid <= 1'b0;
            unique case (state_reg)
                rbsa_pkg::ST_IDLE: begin
                    if (q_valid && q_ready) begin
                        cur_reg <= q_item;
                        state_reg <= rbsa_pkg::ST_RD;
                    end
                end
                rbsa_pkg::ST_RD: begin
                    rec_reg <= rd_rec;
                    step_reg <= '0;
                    rem_reg <= '0;
                    ph_reg <= 2'd0;
                    if (cur_reg.cmd == rbsa_pkg::CMD_ACCUM) begin
                        if (rd_rec.n == rbsa_pkg::CNT_MAX) begin
                            state_reg <= rbsa_pkg::ST_IDLE;
                        end else begin
                            num_reg <= NW'({cur_reg.m, F'(0)});
                            den_reg <= cur_reg.cov;
                            state_reg <= rbsa_pkg::ST_DIVB;
                        end
                    end else begin
                        num_reg <= NW'(rd_rec.sum);
                        den_reg <= 33'(rd_rec.n);
                        state_reg <= rbsa_pkg::ST_RDIV;
                    end
                end
                rbsa_pkg::ST_DIVB: begin
                    // One quotient bit a cycle.
                    if (rem_sh >= {1'b0, den_reg}) begin
                        rem_reg <= rem_sh - {1'b0, den_reg};
                        num_reg <= {num_reg[NW-2:0], 1'b1};
                    end else begin
                        rem_reg <= rem_sh;
                        num_reg <= {num_reg[NW-2:0], 1'b0};
                    end
                    step_reg <= step_reg + 6'd1;
                    if (step_reg == 6'(NW - 1)) state_reg <= rbsa_pkg::ST_SQ;
                end
                rbsa_pkg::ST_SQ: begin
                    x_reg <= num_reg[BW-1:0];
                    mean_reg <= num_reg[BW-1:0];
                    state_reg <= rbsa_pkg::ST_WR;
                end
                rbsa_pkg::ST_WR: begin
                    state_reg <= rbsa_pkg::ST_IDLE;
                end
                rbsa_pkg::ST_RDIV: begin
                    // Four divisions by count, group counts in turn.
                    if (step_reg != 6'(NW)) begin
                        if (rem_sh >= {1'b0, den_reg}) begin
                            rem_reg <= rem_sh - {1'b0, den_reg};
                            num_reg <= {num_reg[NW-2:0], 1'b1};
                        end else begin
                            rem_reg <= rem_sh;
                            num_reg <= {num_reg[NW-2:0], 1'b0};
                        end
                        step_reg <= step_reg + 6'd1;
                    end else begin
                        step_reg <= '0;
                        rem_reg <= '0;
                        ph_reg <= ph_reg + 2'd1;
                        unique case (ph_reg)
                            2'd0: begin
                                mean_reg <= num_reg[BW-1:0];
                                x_reg <= num_reg[BW-1:0];
                                num_reg <= NW'(rec_reg.sq);
                                den_reg <= 33'(rec_reg.n);
                            end
                            2'd1: begin
                                e2_reg <= num_reg[31:0];
                                num_reg <= NW'(rec_reg.hsum);
                                den_reg <= 33'(rec_reg.hn);
                            end
                            2'd2: begin
                                hm_reg <= num_reg[BW-1:0];
                                num_reg <= NW'(rec_reg.lsum);
                                den_reg <= 33'(rec_reg.ln);
                            end
                            default: begin
                                lm_reg <= num_reg[BW-1:0];
                                sb_reg <= SW'(1) << (SW - 2);
                                sr_reg <= '0;
                                if (rec_reg.n == 16'd0 ||
                                    {1'b0, e2_reg} <= 33'(prod >> F)) begin
                                    sv_reg <= '0;
                                end else begin
                                    sv_reg <= SW'(e2_reg - 32'(prod >> F)) << F;
                                end
                                state_reg <= rbsa_pkg::ST_SQRT;
                            end
                        endcase
                    end
                end
                rbsa_pkg::ST_SQRT: begin
                    // One result bit a cycle until the probe bit has run out.
                    if (sb_reg == SW'(0)) begin
                        state_reg <= rbsa_pkg::ST_OUT;
                    end else begin
                        if (sv_reg >= sr_reg + sb_reg) begin
                            sv_reg <= sv_reg - (sr_reg + sb_reg);
                            sr_reg <= (sr_reg >> 1) + sb_reg;
                        end else begin
                            sr_reg <= sr_reg >> 1;
                        end
                        sb_reg <= sb_reg >> 2;
                    end
                end
                rbsa_pkg::ST_OUT: begin
                    o_valid <= 1'b1;
                    o_row <= cur_reg.row;
                    o_has <= cur_reg.row_ok && rec_reg.n != 16'd0;
                    o_both <= cur_reg.row_ok && rec_reg.ln != 16'd0 && rec_reg.hn != 16'd0;
                    if (!cur_reg.row_ok) begin
                        o_n <= '0;
                        o_mn <= '0;
                    end else begin
                        o_n <= rec_reg.n;
                        o_mn <= (rec_reg.ln < rec_reg.hn) ? rec_reg.ln : rec_reg.hn;
                    end
                    if (cur_reg.row_ok && rec_reg.n != 16'd0) begin
                        o_mean <= mean_reg;
                        o_sd <= sr_reg[BW-1:0];
                    end else begin
                        o_mean <= '0;
                        o_sd <= '0;
                    end
                    if (cur_reg.row_ok && rec_reg.ln != 16'd0 && rec_reg.hn != 16'd0) begin
                        o_gap <= (rec_reg.hmin >= rec_reg.lmax) ? rec_reg.hmin - rec_reg.lmax : '0;
                        o_sep <= (hm_reg >= lm_reg) ? hm_reg - lm_reg : '0;
                    end else begin
                        o_gap <= '0;
                        o_sep <= '0;
                    end
                    state_reg <= rbsa_pkg::ST_IDLE;
                end
                default: state_reg <= rbsa_pkg::ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: sv/row_beta_statistics_accumulator.sv
`default_nettype none
// Per-row beta statistics. Items are carried out one at a time. An accumulate
// transfer occupies the engine for the 49-step bit-serial beta divider and the
// row update; a report transfer runs four serial divisions on the shared divider
// and then the serial square root before its result is given, and while a result
// waits on m_tready no further item is started. After reset a clearing pass
// writes each of the ROW_COUNT (rounded up to a power of two) rows before the
// first item is carried out; up to two items queue at the input meanwhile.
// Skipped accumulates are dropped at the input without reaching the engine.
module row_beta_statistics_accumulator #(
    parameter int unsigned ROW_COUNT = 4096,
    parameter int unsigned BETA_FRAC_BITS = 16
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cfg_we,
    input  wire logic [31:0]   cfg_wdata,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    // row_index[11:0], methylated_count[43:12], unmethylated_count[75:44], zeros
    input  wire logic [79:0]   s_tdata,
    // cmd
    input  wire logic          s_tuser,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // report_row, sample_count, avg_beta, sd_beta, gap_beta, min_group_size,
    // mean_separation, has_samples, has_both_groups, then zero fill
    output logic [((12+16*2+4*(BETA_FRAC_BITS+1)+2+7)/8)*8-1:0] m_tdata
);
    localparam int unsigned BW = BETA_FRAC_BITS + 1;
    localparam int unsigned OW = 12 + 32 + 4*BW + 2;
    localparam int unsigned OP = ((OW + 7) / 8) * 8;

    logic              q_valid, q_ready;
    rbsa_pkg::item_t   q_item;
    logic [11:0]       o_row;
    logic [15:0]       o_n, o_mn;
    logic [BW-1:0]     o_mean, o_sd, o_gap, o_sep;
    logic              o_has, o_both, fr_ready;

    assign s_tready = fr_ready;

    rbsa_front #(.ROW_COUNT(ROW_COUNT)) u_front (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(s_tvalid), .in_ready(fr_ready), .in_cmd(s_tuser),
        .in_row(s_tdata[11:0]), .in_m(s_tdata[43:12]), .in_u(s_tdata[75:44]),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    rbsa_back #(.ROW_COUNT(ROW_COUNT), .BETA_FRAC_BITS(BETA_FRAC_BITS)) u_back (
        .aclk(aclk), .aresetn(aresetn), .q_valid(q_valid), .q_ready(q_ready),
        .q_item(q_item), .o_valid(m_tvalid), .o_ready(m_tready),
        .o_row(o_row), .o_n(o_n), .o_mean(o_mean), .o_sd(o_sd), .o_gap(o_gap),
        .o_mn(o_mn), .o_sep(o_sep), .o_has(o_has), .o_both(o_both)
    );

    // Result packing, first field lowest.
    assign m_tdata = {(OP-OW)'(0), o_both, o_has, o_sep, o_mn, o_gap, o_sd,
                      o_mean, o_n, o_row};
endmodule
`default_nettype wire

// File: sv/rbsa_checker.sv
`default_nettype none
module rbsa_checker #(
    parameter int unsigned BETA_FRAC_BITS = 16
) (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [((12+16*2+4*(BETA_FRAC_BITS+1)+2+7)/8)*8-1:0] m_tdata
);
    localparam int unsigned BW = BETA_FRAC_BITS + 1;
    localparam int unsigned MEAN_LO = 28;
    localparam int unsigned GAP_LO = 28 + 2*BW;
    localparam int unsigned SEP_LO = 44 + 3*BW;
    localparam int unsigned HAS_BIT = 44 + 4*BW;
    localparam int unsigned BOTH_BIT = 45 + 4*BW;

    // A waiting result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
    // Mean and sd are zero when the row is empty.
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[HAS_BIT] |-> m_tdata[MEAN_LO +: 2*BW] == '0)
        else $error("empty row reports statistics");
    // Separation and gap are zero without both groups.
    a_groups: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[BOTH_BIT]
        |-> m_tdata[GAP_LO +: BW] == '0 && m_tdata[SEP_LO +: BW] == '0)
        else $error("missing group reports gap");
    // Nothing is valid just after reset, and the input queue is open.
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid && s_tready)
        else $error("bad state after reset");
endmodule
bind row_beta_statistics_accumulator rbsa_checker #(.BETA_FRAC_BITS(BETA_FRAC_BITS))
    u_rbsa_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire
